### rtl/sse_pkg.sv
// Shared types and constants of the subset-sum enumerator.
`default_nettype none
package sse_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int DATA_W = 32;
  localparam int MASK_W = 16;
  localparam int SIZE_W = 5;
  localparam int ADDR_W = 3;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_FETCH  = 2'd2;

  localparam logic REG_TARGET = 1'b0;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [MASK_W-1:0] subset_mask;
    logic [SIZE_W-1:0] member_count;
    logic              match_valid;
    logic              search_done;
    logic              none_found;
    logic              load_dropped;
  } out_t;

  typedef struct packed {
    logic take_in;
    logic simple;
    logic scan_start;
    logic scan_step;
    logic check;
    logic out_load;
  } sse_cmd_t;

  typedef struct packed {
    logic is_fetch;
    logic cursor_zero;
    logic cursor_one;
    logic last_issue;
    logic hit;
    logic out_free;
  } sse_stat_t;

endpackage
`default_nettype wire

### rtl/subset_sum_enumerator.sv
// Subset-sum enumerator top level: configuration port, sequencer and datapath.
//
// Holds up to MAX_ITEMS signed 32-bit elements and, one per fetch, reports each
// non-empty subset whose exact sum equals target_sum, walking a mask counter from
// all ones down to one with element 0 as its most significant bit. A clear, an
// append or a fetch on an exhausted search goes from decode straight to finish.
// A fetch tests masks until a match or exhaustion: with n the element count, each
// mask reads the n elements through the store's single read port, one per cycle,
// then drains and compares. One item is in work at a time; the next transfer is
// taken once the result has moved to the output register, even if that result is
// not yet taken. target_sum lies at byte address 0; the user must write it only
// while the block is idle, and the block itself does not enforce this.
`default_nettype none
module subset_sum_enumerator
  import sse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic signed [DATA_W-1:0] target;
  logic                     target_sel;
  sse_cmd_t                 cmd;
  sse_stat_t                stat;

  assign pready     = 1'b1;
  assign target_sel = (paddr[ADDR_W-1:2] == REG_TARGET);
  assign prdata     = target_sel ? target : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (psel && penable && pwrite && pready && target_sel) begin
      target <= pwdata;
    end
  end

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sse_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .target    (target),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

### rtl/sse_ctrl.sv
// Sequencer of the subset-sum enumerator.
`default_nettype none
module sse_ctrl
  import sse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sse_stat_t stat,
  output sse_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_CHECK  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_fetch && !stat.cursor_zero) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.simple = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.hit || stat.cursor_one) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/sse_dp.sv
// Datapath of the subset-sum enumerator: element store, search cursor, sum and result.
`default_nettype none
module sse_dp
  import sse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire in_t                      in_data,
  input  wire logic signed [DATA_W-1:0] target,
  input  wire sse_cmd_t                 cmd,
  output sse_stat_t                     stat,
  output out_t                          out_data,
  output logic                          out_valid,
  input  wire logic                     out_ready
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUM_W = DATA_W + CNT_W;

  in_t                      in_reg;
  logic signed [DATA_W-1:0] store [MAX_ITEMS];
  logic [CNT_W-1:0]         count;
  logic [MAX_ITEMS-1:0]     full_mask;
  logic [MAX_ITEMS-1:0]     cursor;
  logic                     found_any;
  logic [IDX_W-1:0]         k;
  logic signed [DATA_W-1:0] rd_data;
  logic                     pipe_vld;
  logic                     pipe_inc;
  logic [IDX_W-1:0]         pipe_pos;
  logic signed [SUM_W-1:0]  sum;
  logic [MAX_ITEMS-1:0]     sel;
  logic [CNT_W-1:0]         cnt;
  out_t                     res;

  logic [CNT_W-1:0]     bitpos;
  logic                 hit;
  logic                 list_full;
  logic [MAX_ITEMS-1:0] full_mask_next;
  out_t                 res_next;

  assign bitpos         = count - CNT_W'(1) - CNT_W'(k);
  assign hit            = (sum == SUM_W'(target));
  assign list_full      = (count == CNT_W'(MAX_ITEMS));
  assign full_mask_next = (full_mask << 1) | MAX_ITEMS'(1);

  assign stat.is_fetch    = (in_reg.kind == KIND_FETCH);
  assign stat.cursor_zero = (cursor == '0);
  assign stat.cursor_one  = (cursor == MAX_ITEMS'(1));
  assign stat.last_issue  = (CNT_W'(k) == count - CNT_W'(1));
  assign stat.hit         = hit;
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.simple && in_reg.kind == KIND_APPEND && !list_full) begin
      store[count[IDX_W-1:0]] <= in_reg.value;
    end
    if (cmd.scan_step) begin
      rd_data <= store[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      full_mask <= '0;
      cursor    <= '0;
      found_any <= 1'b0;
    end else if (cmd.simple) begin
      unique case (in_reg.kind)
        KIND_CLEAR: begin
          count     <= '0;
          full_mask <= '0;
          cursor    <= '0;
          found_any <= 1'b0;
        end
        KIND_APPEND: begin
          if (!list_full) begin
            count     <= count + CNT_W'(1);
            full_mask <= full_mask_next;
            cursor    <= full_mask_next;
            found_any <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.check) begin
      cursor <= cursor - MAX_ITEMS'(1);
      if (hit) begin
        found_any <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.check) begin
      k   <= '0;
      sum <= '0;
      sel <= '0;
      cnt <= '0;
    end else begin
      if (cmd.scan_step) begin
        pipe_inc <= cursor[bitpos[IDX_W-1:0]];
        pipe_pos <= k;
        k        <= k + IDX_W'(1);
      end
      if (pipe_vld && pipe_inc) begin
        sum           <= sum + SUM_W'(rd_data);
        sel[pipe_pos] <= 1'b1;
        cnt           <= cnt + CNT_W'(1);
      end
    end
  end

  always_comb begin
    res_next = '0;
    if (cmd.simple) begin
      if (in_reg.kind == KIND_APPEND && list_full) begin
        res_next.load_dropped = 1'b1;
      end
      if (in_reg.kind == KIND_FETCH) begin
        res_next.search_done = 1'b1;
        res_next.none_found  = !found_any;
      end
    end else if (cmd.check) begin
      if (hit) begin
        res_next.subset_mask  = MASK_W'(sel);
        res_next.member_count = SIZE_W'(cnt);
        res_next.match_valid  = 1'b1;
        res_next.search_done  = (cursor == MAX_ITEMS'(1));
      end else if (cursor == MAX_ITEMS'(1)) begin
        res_next.search_done = 1'b1;
        res_next.none_found  = !found_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.simple || cmd.check) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    (cursor & ~full_mask) == '0)
    else $error("search cursor names an element beyond the list");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("element count exceeds capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwrites an untaken result");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> cnt <= count)
    else $error("subset size exceeds element count");

endmodule
`default_nettype wire

### tb/sv/subset_sum_checker.sv
`timescale 1ns / 100ps
// Result checker for the subset-sum enumerator: tracks the list and search, compares results.
module subset_sum_checker
  import sse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                mismatches,
  output int                outstanding
);

  logic signed [DATA_W-1:0] elements [MAX_ITEMS];
  int                       element_count;
  logic [31:0]              cursor;
  bit                       found_any;
  logic signed [DATA_W-1:0] target_sum;
  out_t                     expected_results [$];
  int                       errors;

  function automatic out_t predict_result(input in_t item);
    out_t        r;
    logic [31:0] m;
    logic [31:0] sel;
    longint      sum;
    int          cnt;
    bit          hit;
    r = '0;
    case (item.kind)
      KIND_CLEAR: begin
        element_count = 0;
        cursor = '0;
        found_any = 1'b0;
      end
      KIND_APPEND: begin
        if (element_count >= MAX_ITEMS) begin
          r.load_dropped = 1'b1;
        end else begin
          elements[element_count] = item.value;
          element_count++;
          cursor = (32'd1 << element_count) - 32'd1;
          found_any = 1'b0;
        end
      end
      KIND_FETCH: begin
        hit = 1'b0;
        while (cursor != 0 && !hit) begin
          m = cursor;
          sum = 0;
          sel = '0;
          cnt = 0;
          for (int i = 0; i < element_count; i++) begin
            if (m[element_count - 1 - i]) begin
              sum += elements[i];
              sel[i] = 1'b1;
              cnt++;
            end
          end
          cursor = m - 32'd1;
          if (sum == target_sum) begin
            hit = 1'b1;
            r.subset_mask = sel[MASK_W-1:0];
            r.member_count = SIZE_W'(cnt);
          end
        end
        if (hit) begin
          r.match_valid = 1'b1;
          found_any = 1'b1;
        end
        if (cursor == 0) begin
          r.search_done = 1'b1;
          r.none_found = !found_any;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [MASK_W-1:0] want,
                               input logic [MASK_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      element_count = 0;
      cursor = '0;
      found_any = 1'b0;
      target_sum = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          target_sum = pwdata;
        end else if (prdata !== target_sum) begin
          errors++;
          $display("%0t mismatch in target_sum read: expected %0h, actual %0h",
                   $time, target_sum, prdata);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %0h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          compare_field("subset_mask", want.subset_mask, out_data.subset_mask);
          compare_field("member_count", MASK_W'(want.member_count),
                        MASK_W'(out_data.member_count));
          compare_field("match_valid", MASK_W'(want.match_valid),
                        MASK_W'(out_data.match_valid));
          compare_field("search_done", MASK_W'(want.search_done),
                        MASK_W'(out_data.search_done));
          compare_field("none_found", MASK_W'(want.none_found),
                        MASK_W'(out_data.none_found));
          compare_field("load_dropped", MASK_W'(want.load_dropped),
                        MASK_W'(out_data.load_dropped));
        end
      end
    end
    mismatches <= errors;
    outstanding <= expected_results.size();
  end

endmodule

### tb/sv/tb_subset_sum_enumerator.sv
`timescale 1ns / 100ps
// Testbench top for the subset-sum enumerator: clock, reset, stimulus and verdict.
module tb_subset_sum_enumerator;
  import sse_pkg::*;

  localparam logic [1:0]        KIND_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] TARGET_ADDR = ADDR_W'({REG_TARGET, 2'b00});
  localparam int                LIST_CAP    = 8;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  int                sent;
  int                list_len;

  subset_sum_enumerator dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  subset_sum_checker results_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : receiver
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (taken == 200 && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= (taken >= 400 && taken < 520) || $urandom_range(99) >= 36;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($urandom_range(0, 16)) - 32'd8;
      5, 6, 7:       return $urandom;
      8:             return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      default:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [31:0] value);
    in_t item;
    item.kind = kind;
    item.value = value;
    while (!(sent >= 330 && sent < 450) && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind != KIND_UNUSED) sent++;
    if (kind == KIND_CLEAR) list_len = 0;
    else if (kind == KIND_APPEND && list_len < MAX_ITEMS_DEF) list_len++;
  endtask

  task automatic apb_access(input logic write_en, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write_en;
    paddr <= TARGET_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_phase(input logic [31:0] target, input int n_items);
    logic signed [31:0] vals [LIST_CAP];
    logic [1:0]         kind;
    logic [31:0]        v;
    longint             partial;
    longint             wanted;
    int                 start;
    int                 count;
    wait_idle();
    apb_access(1'b1, target);
    apb_access(1'b0, '0);
    start = sent;
    while (sent - start < n_items) begin
      if ($urandom_range(99) < 12) begin
        kind = 2'($urandom_range(0, 3));
        if (kind == KIND_APPEND && list_len >= LIST_CAP) kind = KIND_UNUSED;
        send_item(kind, pick_value());
      end else begin
        if ($urandom_range(99) < 85) send_item(KIND_CLEAR, $urandom);
        count = ($urandom_range(99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, LIST_CAP);
        if (count > LIST_CAP - list_len) count = LIST_CAP - list_len;
        for (int i = 0; i < count; i++) begin
          v = pick_value();
          // plant a subset that hits the target
          if (i == count - 1 && i > 0 && $urandom_range(1) == 1) begin
            partial = 0;
            for (int j = 0; j < i; j++) begin
              if ($urandom_range(1) == 1) partial += vals[j];
            end
            wanted = longint'($signed(target)) - partial;
            if (wanted == longint'($signed(wanted[31:0]))) v = wanted[31:0];
          end
          vals[i] = v;
          send_item(KIND_APPEND, v);
        end
        repeat ($urandom_range(1, 8)) send_item(KIND_FETCH, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent = 0;
    list_len = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    apb_access(1'b0, '0);

    send_item(KIND_FETCH, $urandom);
    send_item(KIND_UNUSED, $urandom);
    send_item(KIND_APPEND, 32'h8000_0000);
    send_item(KIND_APPEND, 32'h8000_0000);
    send_item(KIND_APPEND, 32'h7FFF_FFFF);
    send_item(KIND_APPEND, 32'h7FFF_FFFF);
    send_item(KIND_FETCH, $urandom);
    send_item(KIND_FETCH, $urandom);

    wait_idle();
    apb_access(1'b1, 32'hFFFF_FFF8);
    apb_access(1'b0, '0);
    send_item(KIND_CLEAR, $urandom);
    for (int i = 0; i < MAX_ITEMS_DEF; i++) begin
      send_item(KIND_APPEND, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end
    send_item(KIND_FETCH, $urandom);
    send_item(KIND_APPEND, $urandom);
    send_item(KIND_CLEAR, $urandom);

    random_phase(32'd3, 125);
    random_phase(32'h8000_0000, 125);
    random_phase(32'h7FFF_FFFF, 125);
    random_phase(32'($urandom_range(0, 20)) - 32'd10, 125);
    random_phase($urandom, 125);
    random_phase(32'd0, 125);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### subset_sum_enumerator.f
rtl/sse_pkg.sv
rtl/sse_ctrl.sv
rtl/sse_dp.sv
rtl/subset_sum_enumerator.sv
tb/sv/subset_sum_checker.sv
tb/sv/tb_subset_sum_enumerator.sv
